>>> hdl/gfts_pkg.sv
// Shared types, codes and sizes of the GOP frame type sequencer.
package gfts_pkg;

   // Default sizes of the frame table and of the B run.
   localparam int MAX_GOP_DEF     = 1024;
   localparam int MAX_BFRAMES_DEF = 31;

   // Field widths.
   localparam int SLOT_W  = 11;
   localparam int INDEX_W = 10;
   localparam int BCNT_W  = 10;
   localparam int DEPTH_W = 4;
   localparam int LEVEL_W = 3;
   localparam int DIST_W  = 6;
   localparam int LEFT_W  = 7;
   localparam int RUN_W   = 5;
   localparam int OP_W    = 2;
   localparam int TYPE_W  = 2;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_IDR_PERIOD   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IP_PERIOD    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_INTRA_PERIOD = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_EXTRA_INTRA  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_BFRAME_COUNT = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PYR_ENABLE   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_PYR_DEPTH    = 3'd6;

   // Operation codes of a request word.
   localparam logic [OP_W-1:0] OP_NEXT    = 2'd0;
   localparam logic [OP_W-1:0] OP_SEEK    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   // Frame type codes.
   localparam logic [TYPE_W-1:0] FT_P = 2'd0;
   localparam logic [TYPE_W-1:0] FT_B = 2'd1;
   localparam logic [TYPE_W-1:0] FT_I = 2'd2;

   // One pyramid entry: level and reference distance magnitudes.
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [DIST_W-1:0]  left_mag;
      logic [DIST_W-1:0]  right;
   } pyr_entry_type;

   // One frame table entry.
   typedef struct packed {
      logic [TYPE_W-1:0]  ftype;
      logic               ref_flag;
      logic [LEVEL_W-1:0] level;
      logic [DIST_W-1:0]  left_mag;
      logic [DIST_W-1:0]  right;
   } frame_entry_type;

   // Control between the sequencer and the pyramid builder.
   typedef struct packed {
      logic               start;
      logic [RUN_W-1:0]   run_len;
      logic [DEPTH_W-1:0] depth;
   } pyr_ctrl_type;

endpackage

>>> hdl/gfts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gfts_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/gfts_pyr.sv
// Pyramid builder: midpoint subdivision of the B run, one step per cycle.
module gfts_pyr #(
   parameter int MAX_BFRAMES = gfts_pkg::MAX_BFRAMES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gfts_pkg::pyr_ctrl_type                 ctrl,
   output logic                                   busy,
   input  logic [gfts_pkg::RUN_W-1:0]             rd_idx,
   output gfts_pkg::pyr_entry_type                rd_entry
);
   import gfts_pkg::*;

   localparam int PW = (MAX_BFRAMES > 1) ? $clog2(MAX_BFRAMES) : 1;

   logic                busy_ff, busy_in;
   logic [RUN_W-1:0]    p_ff, p_in;
   logic [RUN_W-1:0]    s_ff, s_in;
   logic [RUN_W-1:0]    n_ff, n_in;
   logic [DEPTH_W-1:0]  lv_ff, lv_in;
   logic [RUN_W-1:0]    len_ff, len_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   pyr_entry_type       tbl_ff [MAX_BFRAMES];

   logic [RUN_W-1:0]    off;
   logic [RUN_W-1:0]    mid;
   logic [RUN_W-1:0]    off_inc;
   logic [RUN_W-1:0]    span;
   logic                stop;
   pyr_entry_type       new_entry;

   // One subdivision step: compare the offset with the midpoint.
   always_comb begin
      off      = p_ff - s_ff;
      mid      = n_ff >> 1;
      off_inc  = off + RUN_W'(1);
      span     = n_ff - off;
      stop     = (lv_ff == depth_ff) || (n_ff == RUN_W'(1)) || (off == mid);
      new_entry.level    = lv_ff[LEVEL_W-1:0];
      new_entry.left_mag = {off_inc, 1'b0};
      new_entry.right    = {span, 1'b0};
   end

   // Walk the B positions and the subdivision levels of each.
   always_comb begin
      busy_in  = busy_ff;
      p_in     = p_ff;
      s_in     = s_ff;
      n_in     = n_ff;
      lv_in    = lv_ff;
      len_in   = len_ff;
      depth_in = depth_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         p_in     = '0;
         s_in     = '0;
         n_in     = ctrl.run_len;
         lv_in    = '0;
         len_in   = ctrl.run_len;
         depth_in = ctrl.depth;
      end else if (busy_ff) begin
         if (stop) begin
            p_in  = p_ff + RUN_W'(1);
            s_in  = '0;
            n_in  = len_ff;
            lv_in = '0;
            if (p_ff + RUN_W'(1) == len_ff) begin
               busy_in = 1'b0;
            end
         end else begin
            if (off < mid) begin
               n_in = mid;
            end else begin
               s_in = s_ff + mid + RUN_W'(1);
               n_in = n_ff - mid - RUN_W'(1);
            end
            lv_in = lv_ff + DEPTH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      p_ff     <= p_in;
      s_ff     <= s_in;
      n_ff     <= n_in;
      lv_ff    <= lv_in;
      len_ff   <= len_in;
      depth_ff <= depth_in;
      if (busy_ff && !ctrl.start && stop) begin
         tbl_ff[p_ff[PW-1:0]] <= new_entry;
      end
   end

   assign busy     = busy_ff;
   assign rd_entry = tbl_ff[rd_idx[PW-1:0]];

endmodule

>>> hdl/gfts_mod.sv
// Restoring modulo unit: one quotient bit per cycle.
module gfts_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gfts_pkg::SLOT_W-1:0] dividend,
   input  logic [gfts_pkg::SLOT_W-1:0] divisor,
   output logic                        busy,
   output logic [gfts_pkg::SLOT_W-1:0] remainder
);
   import gfts_pkg::*;

   localparam int CNT_W = $clog2(SLOT_W + 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SLOT_W-1:0]   quo_ff, quo_in;
   logic [SLOT_W:0]     rem_ff, rem_in;
   logic [SLOT_W-1:0]   div_ff, div_in;
   logic [SLOT_W:0]     trial;

   // Shift in the next dividend bit and subtract where it fits.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff[SLOT_W-1:0], quo_ff[SLOT_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SLOT_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SLOT_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff[SLOT_W-1:0];

endmodule

>>> hdl/gop_frame_type_sequencer.sv
// GOP frame type sequencer: top level with sequencer, registers and frame table.
//
// Hands out the frame types of one group of pictures, one result word per
// "next" request. A seek or restart request gives no result. A "next" on a
// built table passes through the read state, which addresses the frame
// table, and the emit state, which takes its registered read into the
// result word. The block takes requests only in its idle state and not
// while a result word waits, so a new "next" is taken only after the last
// result word has been taken. The first "next" after reset or a register
// write also checks the settings and builds the table: a check state, then,
// when a pyramid depth is set, the pyramid builder walks the subdivision
// steps of every B position, then the table is filled one GOP slot per
// cycle, then the modulo unit brings the slot index into the new GOP.
module gop_frame_type_sequencer #(
   parameter int MAX_BFRAMES = gfts_pkg::MAX_BFRAMES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gfts_pkg::OP_W-1:0]          req_operation,
   input  logic [gfts_pkg::INDEX_W-1:0]       req_seek_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_frame_valid,
   output logic [gfts_pkg::INDEX_W-1:0]       rsp_frame_index,
   output logic [gfts_pkg::TYPE_W-1:0]        rsp_frame_type,
   output logic                               rsp_is_reference,
   output logic [gfts_pkg::LEVEL_W-1:0]       rsp_pyr_level,
   output logic signed [gfts_pkg::LEFT_W-1:0] rsp_left_ref_distance,
   output logic [gfts_pkg::DIST_W-1:0]        rsp_right_ref_distance,
   output logic                               rsp_gop_last,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gfts_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gfts_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gfts_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import gfts_pkg::*;

   localparam int MAX_GOP = MAX_GOP_DEF;
   localparam int AW = $clog2(MAX_GOP);
   localparam int FW = $bits(frame_entry_type);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_PYR   = 3'd2;
   localparam logic [2:0] S_FILL  = 3'd3;
   localparam logic [2:0] S_MOD   = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   // Configuration registers.
   logic [SLOT_W-1:0]  idr_ff, ip_ff, intra_ff, extra_ff;
   logic [BCNT_W-1:0]  bcnt_ff;
   logic               pen_ff;
   logic [DEPTH_W-1:0] depth_ff;

   // Control state.
   logic [2:0]         state_ff, state_in;
   logic               table_ready_ff, table_ready_in;
   logic               settings_ok_ff, settings_ok_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [SLOT_W-1:0]  intra_left_ff, intra_left_in;
   logic [SLOT_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0]  m_ip_ff, m_ip_in;
   logic [SLOT_W-1:0]  m_intra_ff, m_intra_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   // Result word.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      fvalid_ff, fvalid_in;
   logic [INDEX_W-1:0]        findex_ff, findex_in;
   logic [TYPE_W-1:0]         ftype_ff, ftype_in;
   logic                      fref_ff, fref_in;
   logic [LEVEL_W-1:0]        flevel_ff, flevel_in;
   logic signed [LEFT_W-1:0]  fleft_ff, fleft_in;
   logic [DIST_W-1:0]         fright_ff, fright_in;
   logic                      flast_ff, flast_in;

   logic               csr_write;
   logic [REG_IDX_W-1:0] csr_idx;
   logic               req_fire;
   logic               settings_good;
   logic               fill_last;
   logic [SLOT_W-1:0]  idr_m1;
   logic [SLOT_W-1:0]  read_slot;
   frame_entry_type    fill_entry;
   frame_entry_type    rd_entry;
   logic [FW-1:0]      rd_word;
   logic               ram_we;
   logic [AW-1:0]      ram_rd_addr;

   pyr_ctrl_type       pyr_ctrl;
   logic               pyr_busy;
   logic [RUN_W-1:0]   pyr_idx;
   pyr_entry_type      pyr_entry;

   logic               mod_start;
   logic               mod_busy;
   logic [SLOT_W-1:0]  mod_rem;

   // Configuration port: writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_idx)
         REG_IDR_PERIOD:   csr_prdata = CSR_DATA_W'(idr_ff);
         REG_IP_PERIOD:    csr_prdata = CSR_DATA_W'(ip_ff);
         REG_INTRA_PERIOD: csr_prdata = CSR_DATA_W'(intra_ff);
         REG_EXTRA_INTRA:  csr_prdata = CSR_DATA_W'(extra_ff);
         REG_BFRAME_COUNT: csr_prdata = CSR_DATA_W'(bcnt_ff);
         REG_PYR_ENABLE:   csr_prdata = CSR_DATA_W'(pen_ff);
         REG_PYR_DEPTH:    csr_prdata = CSR_DATA_W'(depth_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idr_ff   <= '0;
         ip_ff    <= '0;
         intra_ff <= '0;
         extra_ff <= '0;
         bcnt_ff  <= '0;
         pen_ff   <= 1'b0;
         depth_ff <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_IDR_PERIOD:   idr_ff   <= csr_pwdata[SLOT_W-1:0];
            REG_IP_PERIOD:    ip_ff    <= csr_pwdata[SLOT_W-1:0];
            REG_INTRA_PERIOD: intra_ff <= csr_pwdata[SLOT_W-1:0];
            REG_EXTRA_INTRA:  extra_ff <= csr_pwdata[SLOT_W-1:0];
            REG_BFRAME_COUNT: bcnt_ff  <= csr_pwdata[BCNT_W-1:0];
            REG_PYR_ENABLE:   pen_ff   <= csr_pwdata[0];
            REG_PYR_DEPTH:    depth_ff <= csr_pwdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Settings check.
   always_comb begin
      settings_good = 1'b1;
      if (idr_ff == '0 || 32'(idr_ff) > 32'(MAX_GOP)) begin
         settings_good = 1'b0;
      end
      if (pen_ff && depth_ff == '0) begin
         settings_good = 1'b0;
      end
      if (depth_ff != '0 && (bcnt_ff == '0 || 32'(bcnt_ff) > 32'(MAX_BFRAMES))) begin
         settings_good = 1'b0;
      end
      if (bcnt_ff != '0 && (SLOT_W'(bcnt_ff) + SLOT_W'(1)) != ip_ff) begin
         settings_good = 1'b0;
      end
      if (ip_ff > idr_ff || intra_ff > idr_ff) begin
         settings_good = 1'b0;
      end
   end

   assign idr_m1    = idr_ff - SLOT_W'(1);
   assign fill_last = (fill_ff == idr_m1);
   assign pyr_idx   = RUN_W'(m_ip_ff - SLOT_W'(1));

   // Frame table entry for the slot being filled.
   always_comb begin
      fill_entry = '0;
      if (fill_ff == '0) begin
         fill_entry.ftype    = FT_I;
         fill_entry.ref_flag = 1'b1;
      end else if (ip_ff == '0) begin
         fill_entry.ftype = FT_I;
      end else if (m_ip_ff != '0) begin
         fill_entry.ftype = FT_B;
         if (depth_ff != '0) begin
            fill_entry.level    = pyr_entry.level;
            fill_entry.ref_flag = (DEPTH_W'(pyr_entry.level) < depth_ff);
            fill_entry.left_mag = pyr_entry.left_mag;
            fill_entry.right    = pyr_entry.right;
         end
      end else if (intra_ff != '0 && m_intra_ff == '0 && intra_left_ff != '0) begin
         fill_entry.ftype    = FT_I;
         fill_entry.ref_flag = 1'b1;
      end else begin
         fill_entry.ftype    = FT_P;
         fill_entry.ref_flag = 1'b1;
      end
      // With more than one slot and a nonzero IP period, the last slot of the GOP closes with a reference P frame.
      if (fill_last && idr_ff > SLOT_W'(1) && ip_ff != '0) begin
         fill_entry          = '0;
         fill_entry.ftype    = FT_P;
         fill_entry.ref_flag = 1'b1;
      end
   end

   assign read_slot = (cur_ff == idr_ff) ? '0 : cur_ff;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rd_entry  = frame_entry_type'(rd_word);

   assign pyr_ctrl.start   = (state_ff == S_CHECK) && settings_good && depth_ff != '0;
   assign pyr_ctrl.run_len = RUN_W'(bcnt_ff);
   assign pyr_ctrl.depth   = depth_ff;
   assign mod_start        = (state_ff == S_FILL) && fill_last;
   assign ram_we           = (state_ff == S_FILL);
   assign ram_rd_addr      = AW'(read_slot);

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      table_ready_in = table_ready_ff;
      settings_ok_in = settings_ok_ff;
      cur_in         = cur_ff;
      intra_left_in  = intra_left_ff;
      fill_in        = fill_ff;
      m_ip_in        = m_ip_ff;
      m_intra_in     = m_intra_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff;
      fvalid_in      = fvalid_ff;
      findex_in      = findex_ff;
      ftype_in       = ftype_ff;
      fref_in        = fref_ff;
      flevel_in      = flevel_ff;
      fleft_in       = fleft_ff;
      fright_in      = fright_ff;
      flast_in       = flast_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_operation)
                  OP_SEEK: begin
                     if (table_ready_ff && settings_ok_ff) begin
                        if (SLOT_W'(req_seek_index) < idr_ff) begin
                           cur_in = SLOT_W'(req_seek_index);
                        end else begin
                           cur_in = idr_m1;
                        end
                     end
                  end
                  OP_RESTART: begin
                     cur_in = '0;
                  end
                  OP_NEXT: begin
                     if (!table_ready_ff) begin
                        state_in = S_CHECK;
                     end else if (!settings_ok_ff) begin
                        rsp_valid_in = 1'b1;
                        fvalid_in    = 1'b0;
                        findex_in    = '0;
                        ftype_in     = '0;
                        fref_in      = 1'b0;
                        flevel_in    = '0;
                        fleft_in     = '0;
                        fright_in    = '0;
                        flast_in     = 1'b0;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            table_ready_in = 1'b1;
            settings_ok_in = settings_good;
            intra_left_in  = extra_ff;
            fill_in        = '0;
            m_ip_in        = '0;
            m_intra_in     = '0;
            if (!settings_good) begin
               rsp_valid_in = 1'b1;
               fvalid_in    = 1'b0;
               findex_in    = '0;
               ftype_in     = '0;
               fref_in      = 1'b0;
               flevel_in    = '0;
               fleft_in     = '0;
               fright_in    = '0;
               flast_in     = 1'b0;
               state_in     = S_IDLE;
            end else if (depth_ff != '0) begin
               state_in = S_PYR;
            end else begin
               state_in = S_FILL;
            end
         end
         S_PYR: begin
            if (!pyr_busy) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            // Spend one extra I frame where a P slot turns into I.
            if (fill_ff != '0 && ip_ff != '0 && m_ip_ff == '0 && intra_ff != '0
                && m_intra_ff == '0 && intra_left_ff != '0) begin
               intra_left_in = intra_left_ff - SLOT_W'(1);
            end
            fill_in = fill_ff + SLOT_W'(1);
            if (ip_ff != '0) begin
               m_ip_in = (m_ip_ff + SLOT_W'(1) == ip_ff) ? '0 : m_ip_ff + SLOT_W'(1);
            end
            if (intra_ff != '0) begin
               m_intra_in = (m_intra_ff + SLOT_W'(1) == intra_ff) ? '0
                                                                  : m_intra_ff + SLOT_W'(1);
            end
            if (fill_last) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (!mod_busy) begin
               cur_in   = mod_rem;
               state_in = S_READ;
            end
         end
         S_READ: begin
            slot_in  = read_slot;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            fvalid_in    = 1'b1;
            findex_in    = INDEX_W'(slot_ff);
            ftype_in     = rd_entry.ftype;
            fref_in      = rd_entry.ref_flag;
            flevel_in    = rd_entry.level;
            fleft_in     = -$signed({1'b0, rd_entry.left_mag});
            fright_in    = rd_entry.right;
            flast_in     = (slot_ff == idr_m1);
            cur_in       = slot_ff + SLOT_W'(1);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write sends the next "next" through the check again.
      if (csr_write && (csr_idx == REG_IDR_PERIOD || csr_idx == REG_IP_PERIOD
          || csr_idx == REG_INTRA_PERIOD || csr_idx == REG_EXTRA_INTRA
          || csr_idx == REG_BFRAME_COUNT || csr_idx == REG_PYR_ENABLE
          || csr_idx == REG_PYR_DEPTH)) begin
         table_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         table_ready_ff <= 1'b0;
         settings_ok_ff <= 1'b0;
         cur_ff         <= '0;
         intra_left_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         table_ready_ff <= table_ready_in;
         settings_ok_ff <= settings_ok_in;
         cur_ff         <= cur_in;
         intra_left_ff  <= intra_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      fill_ff    <= fill_in;
      m_ip_ff    <= m_ip_in;
      m_intra_ff <= m_intra_in;
      slot_ff    <= slot_in;
      fvalid_ff  <= fvalid_in;
      findex_ff  <= findex_in;
      ftype_ff   <= ftype_in;
      fref_ff    <= fref_in;
      flevel_ff  <= flevel_in;
      fleft_ff   <= fleft_in;
      fright_ff  <= fright_in;
      flast_ff   <= flast_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frame_valid        = fvalid_ff;
   assign rsp_frame_index        = findex_ff;
   assign rsp_frame_type         = ftype_ff;
   assign rsp_is_reference       = fref_ff;
   assign rsp_pyr_level          = flevel_ff;
   assign rsp_left_ref_distance  = fleft_ff;
   assign rsp_right_ref_distance = fright_ff;
   assign rsp_gop_last           = flast_ff;

   gfts_pyr #(
      .MAX_BFRAMES(MAX_BFRAMES)
   ) u_pyr (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (pyr_ctrl),
      .busy    (pyr_busy),
      .rd_idx  (pyr_idx),
      .rd_entry(pyr_entry)
   );

   gfts_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (cur_ff),
      .divisor  (idr_ff),
      .busy     (mod_busy),
      .remainder(mod_rem)
   );

   gfts_ram #(
      .WIDTH(FW),
      .DEPTH(MAX_GOP)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(AW'(fill_ff)),
      .wr_data(FW'(fill_entry)),
      .rd_addr(ram_rd_addr),
      .rd_data(rd_word)
   );

endmodule

>>> hdl/gfts_checker.sv
// Port-level checks of the GOP frame type sequencer and their binding.
module gfts_props (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_frame_valid,
   input logic [gfts_pkg::INDEX_W-1:0]       rsp_frame_index,
   input logic [gfts_pkg::TYPE_W-1:0]        rsp_frame_type,
   input logic                               rsp_is_reference,
   input logic [gfts_pkg::LEVEL_W-1:0]       rsp_pyr_level,
   input logic signed [gfts_pkg::LEFT_W-1:0] rsp_left_ref_distance,
   input logic [gfts_pkg::DIST_W-1:0]        rsp_right_ref_distance,
   input logic                               rsp_gop_last
);
   import gfts_pkg::*;

   // A waiting result word stays until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   // No request is taken while a result word waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result word waits");

   // A word for invalid settings carries nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_valid |-> rsp_frame_index == '0 && rsp_frame_type == FT_P
         && !rsp_is_reference && rsp_pyr_level == '0 && rsp_left_ref_distance == '0
         && rsp_right_ref_distance == '0 && !rsp_gop_last)
      else $error("invalid-settings word carries data");

   // The first slot of a GOP is the IDR frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid && rsp_frame_index == '0 |->
         rsp_frame_type == FT_I && rsp_is_reference)
      else $error("slot zero is not a reference I frame");

   // Only B frames carry a level and reference distances.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_type != FT_B |-> rsp_pyr_level == '0
         && rsp_left_ref_distance == '0 && rsp_right_ref_distance == '0)
      else $error("anchor frame carries pyramid data");

endmodule

bind gop_frame_type_sequencer gfts_props u_checker (.*);

>>> dv/gfts_checker.sv
// Checker of the GOP frame type sequencer: plans frame types and compares result words.
`timescale 1ns / 100ps

module gfts_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [gfts_pkg::OP_W-1:0]           req_operation,
   input  logic [gfts_pkg::INDEX_W-1:0]        req_seek_index,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_frame_valid,
   input  logic [gfts_pkg::INDEX_W-1:0]        rsp_frame_index,
   input  logic [gfts_pkg::TYPE_W-1:0]         rsp_frame_type,
   input  logic                                rsp_is_reference,
   input  logic [gfts_pkg::LEVEL_W-1:0]        rsp_pyr_level,
   input  logic signed [gfts_pkg::LEFT_W-1:0]  rsp_left_ref_distance,
   input  logic [gfts_pkg::DIST_W-1:0]         rsp_right_ref_distance,
   input  logic                                rsp_gop_last,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gfts_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gfts_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  pending_frames,
   output int                                  frame_count
);
   import gfts_pkg::*;

   localparam int GOP_SLOTS = MAX_GOP_DEF;
   localparam int B_SLOTS   = MAX_BFRAMES_DEF;

   // One planned result word.
   typedef struct {
      logic                     frame_valid;
      logic [INDEX_W-1:0]       frame_index;
      logic [TYPE_W-1:0]        frame_type;
      logic                     is_reference;
      logic [LEVEL_W-1:0]       pyr_level;
      logic signed [LEFT_W-1:0] left_dist;
      logic [DIST_W-1:0]        right_dist;
      logic                     gop_last;
   } frame_word_type;

   // Shadow of the settings registers.
   logic [SLOT_W-1:0]  gop_len;
   logic [SLOT_W-1:0]  anchor_gap;
   logic [SLOT_W-1:0]  intra_period;
   logic [SLOT_W-1:0]  extra_intra;
   logic [BCNT_W-1:0]  bframe_count;
   logic               pyr_enable;
   logic [DEPTH_W-1:0] pyr_depth;

   // Planning state.
   frame_entry_type gop_plan [0:GOP_SLOTS-1];
   pyr_entry_type   b_levels [0:B_SLOTS-1];
   bit              plan_built;
   bit              plan_ok;
   int unsigned     cur_slot;

   frame_word_type planned_frames [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic bit settings_usable();
      if (gop_len == 0 || gop_len > GOP_SLOTS) return 0;
      if (pyr_enable && pyr_depth == 0) return 0;
      if (pyr_depth > 0 && (bframe_count == 0 || bframe_count > B_SLOTS)) return 0;
      if (bframe_count > 0 && bframe_count + 1 != anchor_gap) return 0;
      if (anchor_gap > gop_len) return 0;
      if (intra_period > gop_len) return 0;
      return 1;
   endfunction

   // Midpoint subdivision of one B run, levels capped at the pyramid depth.
   function automatic void plan_pyramid();
      int unsigned s, n, lv, off, mid;
      for (int unsigned p = 0; p < bframe_count && p < B_SLOTS; p++) begin
         s = 0;
         n = bframe_count;
         lv = 0;
         off = 0;
         while (1) begin
            off = p - s;
            if (lv == pyr_depth || n == 1) break;
            mid = n / 2;
            if (off == mid) break;
            if (off < mid) begin
               n = mid;
            end else begin
               s = s + mid + 1;
               n = n - mid - 1;
            end
            lv++;
         end
         b_levels[p].level    = LEVEL_W'(lv);
         b_levels[p].left_mag = DIST_W'(2 * (off + 1));
         b_levels[p].right    = DIST_W'(2 * (n - off));
      end
   endfunction

   // Fill the frame plan of one GOP.
   function automatic void plan_gop();
      int unsigned intra_left, k;
      frame_entry_type e;
      if (pyr_depth > 0) plan_pyramid();
      intra_left = extra_intra;
      for (int unsigned i = 0; i < gop_len && i < GOP_SLOTS; i++) begin
         e = '0;
         if (i == 0) begin
            e.ftype = FT_I;
            e.ref_flag = 1;
         end else if (anchor_gap == 0) begin
            e.ftype = FT_I;
         end else if (i % anchor_gap > 0) begin
            e.ftype = FT_B;
            if (pyr_depth > 0) begin
               k = (i % anchor_gap - 1) % B_SLOTS;
               e.level    = b_levels[k].level;
               e.ref_flag = (e.level < pyr_depth);
               e.left_mag = b_levels[k].left_mag;
               e.right    = b_levels[k].right;
            end
         end else if (intra_period > 0 && i % intra_period == 0 && intra_left > 0) begin
            e.ftype = FT_I;
            e.ref_flag = 1;
            intra_left--;
         end else begin
            e.ftype = FT_P;
            e.ref_flag = 1;
         end
         gop_plan[i] = e;
      end
      // With more than one slot and a nonzero anchor gap, the closing slot is a plain reference P frame.
      if (gop_len > 1 && anchor_gap > 0) begin
         e = '0;
         e.ftype = FT_P;
         e.ref_flag = 1;
         gop_plan[(gop_len - 1) % GOP_SLOTS] = e;
      end
   endfunction

   // Work out the result word of one "next" request.
   function automatic frame_word_type next_frame();
      frame_word_type w;
      int unsigned slot;
      frame_entry_type e;
      w = '{default: '0};
      if (!plan_built) begin
         plan_ok = settings_usable();
         if (plan_ok) plan_gop();
         plan_built = 1;
      end
      if (!plan_ok) return w;
      slot = cur_slot % gop_len;
      e = gop_plan[slot % GOP_SLOTS];
      cur_slot = slot + 1;
      w.frame_valid   = 1;
      w.frame_index   = INDEX_W'(slot);
      w.frame_type    = e.ftype;
      w.is_reference  = e.ref_flag;
      w.pyr_level     = e.level;
      w.left_dist     = LEFT_W'(0) - LEFT_W'(e.left_mag);
      w.right_dist    = e.right;
      w.gop_last      = (slot == gop_len - 1);
      return w;
   endfunction

   // Track register writes, requests and result words at each edge.
   always @(posedge clock) begin
      frame_word_type want;
      if (reset) begin
         gop_len = 0; anchor_gap = 0; intra_period = 0; extra_intra = 0;
         bframe_count = 0; pyr_enable = 0; pyr_depth = 0;
         plan_built = 0;
         plan_ok = 0;
         cur_slot = 0;
         fail_count = 0;
         planned_frames.delete();
         frame_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (REG_IDX_W'(csr_paddr >> 2))
               REG_IDR_PERIOD:   gop_len      = csr_pwdata[SLOT_W-1:0];
               REG_IP_PERIOD:    anchor_gap   = csr_pwdata[SLOT_W-1:0];
               REG_INTRA_PERIOD: intra_period = csr_pwdata[SLOT_W-1:0];
               REG_EXTRA_INTRA:  extra_intra  = csr_pwdata[SLOT_W-1:0];
               REG_BFRAME_COUNT: bframe_count = csr_pwdata[BCNT_W-1:0];
               REG_PYR_ENABLE:   pyr_enable   = csr_pwdata[0];
               REG_PYR_DEPTH:    pyr_depth    = csr_pwdata[DEPTH_W-1:0];
               default: ;
            endcase
            plan_built = 0;
         end
         if (req_valid && req_ready) begin
            case (req_operation)
               OP_NEXT: planned_frames.push_back(next_frame());
               OP_SEEK: begin
                  if (plan_built && plan_ok)
                     cur_slot = (req_seek_index < gop_len) ? req_seek_index
                                                           : gop_len - 1;
               end
               OP_RESTART: cur_slot = 0;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            frame_count <= frame_count + 1;
            if (planned_frames.size() == 0) begin
               report_mismatch("unexpected result word, index", rsp_frame_index, 0);
            end else begin
               want = planned_frames.pop_front();
               if (rsp_frame_valid !== want.frame_valid)
                  report_mismatch("frame_valid", rsp_frame_valid, want.frame_valid);
               if (rsp_frame_index !== want.frame_index)
                  report_mismatch("frame_index", rsp_frame_index, want.frame_index);
               if (rsp_frame_type !== want.frame_type)
                  report_mismatch("frame_type", rsp_frame_type, want.frame_type);
               if (rsp_is_reference !== want.is_reference)
                  report_mismatch("is_reference", rsp_is_reference, want.is_reference);
               if (rsp_pyr_level !== want.pyr_level)
                  report_mismatch("pyr_level", rsp_pyr_level, want.pyr_level);
               if (rsp_left_ref_distance !== want.left_dist)
                  report_mismatch("left_ref_distance", rsp_left_ref_distance,
                                  want.left_dist);
               if (rsp_right_ref_distance !== want.right_dist)
                  report_mismatch("right_ref_distance", rsp_right_ref_distance,
                                  want.right_dist);
               if (rsp_gop_last !== want.gop_last)
                  report_mismatch("gop_last", rsp_gop_last, want.gop_last);
            end
         end
      end
      pending_frames <= planned_frames.size();
   end

endmodule

>>> dv/tb_top.sv
// Testbench top of the GOP frame type sequencer: stimulus, settings and verdict.
`timescale 1ns / 100ps

module tb_top;
   import gfts_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_PHASES = 16;
   localparam int WORDS_PER_PHASE = 125;
   localparam int TOTAL_PHASES = RANDOM_PHASES + 6;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_valid = 0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_operation = OP_NEXT;
   logic [INDEX_W-1:0]        req_seek_index = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 0;
   logic                      rsp_frame_valid;
   logic [INDEX_W-1:0]        rsp_frame_index;
   logic [TYPE_W-1:0]         rsp_frame_type;
   logic                      rsp_is_reference;
   logic [LEVEL_W-1:0]        rsp_pyr_level;
   logic signed [LEFT_W-1:0]  rsp_left_ref_distance;
   logic [DIST_W-1:0]         rsp_right_ref_distance;
   logic                      rsp_gop_last;
   logic                      csr_psel = 0;
   logic                      csr_penable = 0;
   logic                      csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   int fail_count;
   int pending_frames;
   int frame_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int phase_no = 0;
   int word_count = 0;
   int setting_count = 0;
   int stall_cycles = 0;
   int unsigned cur_idr = 0;

   always #6 clock = ~clock;

   gop_frame_type_sequencer i_dut (.*);

   gfts_checker i_checker (.*);

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Choose the idling pattern from how far the run has come.
   task automatic next_phase();
      case (phase_no * 3 / TOTAL_PHASES)
         0: begin send_idle_pct = 32; recv_idle_pct = 81; end
         1: begin send_idle_pct = 81; recv_idle_pct = 32; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_no++;
   endtask

   // Offer one request word and hold it until it is taken.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid      <= 1;
      req_operation  <= op;
      req_seek_index <= idx;
      do @(posedge clock); while (!req_ready);
      if (op != OP_UNUSED) word_count++;
   endtask

   // Wait until every planned result word has come back and the block settles.
   task automatic wait_idle();
      req_valid <= 0;
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // A setup phase and then an access phase; the caller closes the transfer.
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_penable <= 0;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
   endtask

   task automatic apply_settings(input int unsigned idr, input int unsigned ip,
                                 input int unsigned intra, input int unsigned extra,
                                 input int unsigned bcnt, input int unsigned en,
                                 input int unsigned depth);
      wait_idle();
      write_reg(REG_IDR_PERIOD, idr);
      write_reg(REG_IP_PERIOD, ip);
      write_reg(REG_INTRA_PERIOD, intra);
      write_reg(REG_EXTRA_INTRA, extra);
      write_reg(REG_BFRAME_COUNT, bcnt);
      write_reg(REG_PYR_ENABLE, en);
      write_reg(REG_PYR_DEPTH, depth);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      cur_idr = idr & 11'h7FF;
      setting_count++;
      next_phase();
   endtask

   // Mostly consistent settings, sometimes raw bits that are likely rejected.
   task automatic random_settings();
      int unsigned idr, ip, bcnt, depth, en, hi;
      if ($urandom_range(3) == 0) begin
         apply_settings($urandom & 11'h7FF, $urandom & 11'h7FF, $urandom & 11'h7FF,
                        $urandom & 11'h7FF, $urandom & 10'h3FF, $urandom & 1,
                        $urandom & 4'hF);
         return;
      end
      idr = ($urandom_range(7) == 0) ? 1024 : $urandom_range(1, 64);
      depth = 0;
      en = 0;
      case ($urandom_range(3))
         0: begin ip = 0; bcnt = 0; end
         1: begin
            ip = ($urandom_range(3) == 0) ? idr : $urandom_range(1, idr);
            bcnt = ip - 1;
         end
         default: begin
            if (idr < 2) begin
               ip = 1;
               bcnt = 0;
            end else begin
               hi = (idr - 1 < 31) ? idr - 1 : 31;
               bcnt = $urandom_range(1, hi);
               ip = bcnt + 1;
               depth = $urandom_range(1, 15);
               en = $urandom_range(1);
            end
         end
      endcase
      apply_settings(idr, ip, $urandom_range(0, idr),
                     ($urandom_range(1) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 1024),
                     bcnt, en, depth);
   endtask

   initial begin
      logic [OP_W-1:0] op;
      logic [INDEX_W-1:0] idx;
      int unsigned pick;

      repeat (7) @(posedge clock);
      reset <= 0;
      next_phase();

      // Settings after reset are rejected; seeks are ignored without a plan.
      send_word(OP_NEXT, '0);
      send_word(OP_SEEK, 10'd5);
      send_word(OP_UNUSED, 10'h3FF);
      send_word(OP_RESTART, '0);
      send_word(OP_NEXT, '0);

      // Largest GOP, deepest pyramid, intra period and extra intra budget at the GOP length.
      apply_settings(1024, 32, 1024, 1024, 31, 1, 15);
      send_word(OP_NEXT, '0);
      send_word(OP_SEEK, 10'h3FF);
      send_word(OP_NEXT, '0);
      send_word(OP_NEXT, '0);

      // Single-frame GOP, intra only; seek past the end is clamped.
      apply_settings(1, 0, 0, 0, 0, 0, 0);
      send_word(OP_NEXT, '0);
      send_word(OP_SEEK, 10'h3FF);
      send_word(OP_NEXT, '0);

      // Pyramid requested with depth zero is rejected.
      apply_settings(8, 4, 0, 0, 3, 1, 0);
      send_word(OP_NEXT, '0);

      // Flat B frames with extra intra anchors, then the wrap at the GOP end.
      apply_settings(30, 3, 6, 2, 2, 0, 0);
      send_word(OP_NEXT, '0);
      send_word(OP_SEEK, 10'd29);
      send_word(OP_NEXT, '0);
      send_word(OP_NEXT, '0);

      // Shallow pyramid, slot index kept across the settings change.
      apply_settings(12, 4, 4, 1, 3, 1, 2);
      send_word(OP_NEXT, '0);
      send_word(OP_NEXT, '0);
      send_word(OP_NEXT, '0);

      // Random phases, each with fresh settings.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_settings();
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            pick = $urandom_range(99);
            if (pick < 72) op = OP_NEXT;
            else if (pick < 84) op = OP_SEEK;
            else if (pick < 95) op = OP_RESTART;
            else op = OP_UNUSED;
            if ($urandom_range(1) == 0 || cur_idr == 0) idx = INDEX_W'($urandom);
            else idx = INDEX_W'($urandom_range(0, (cur_idr > 1023) ? 1023 : cur_idr));
            send_word(op, idx);
         end
      end

      wait_idle();
      $display("Covered %0d request words and %0d result words over %0d register settings,",
               word_count, frame_count, setting_count);
      $display("with valid, rejected and extreme GOP layouts under mixed stalls.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
